// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers used by the checker file wsd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, held off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/wsd_pkg.sv
package wsd_pkg;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DEAD    = 3'd5;

  localparam logic [2:0] ST_FRAGMENT = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_CLOSE    = 3'd2;
  localparam logic [2:0] ST_PING     = 3'd3;
  localparam logic [2:0] ST_PONG     = 3'd4;
  localparam logic [2:0] ST_ERROR    = 3'd5;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_data;
    logic       frame_end;
    logic [2:0] frame_status;
    logic       binary_message;
  } wsd_result_t;

  function automatic logic [2:0] end_code(input logic [3:0] opcode, input logic fin);
    logic [2:0] code;
    code = fin ? ST_COMPLETE : ST_FRAGMENT;
    if (opcode == OP_CLOSE) code = ST_CLOSE;
    if (opcode == OP_PING)  code = ST_PING;
    if (opcode == OP_PONG)  code = ST_PONG;
    return code;
  endfunction

endpackage

// File: rtl/core/wsd_out_reg.sv
module wsd_out_reg import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  wsd_result_t load_result,
  output logic        load_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output wsd_result_t result
);

  logic valid;

  assign load_ready = !valid || m_tready;
  assign m_tvalid   = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

endmodule

// File: rtl/core/websocket_frame_deframer.sv
// WebSocket receive deframer. Takes one frame-stream byte per transaction and can accept a byte
// every cycle while s_tready is high; each byte is parsed by the header/payload state
// register in the cycle it is accepted and its result, if any, appears in the output register
// on the next cycle. s_tready is high whenever the output register is empty or being drained.
// Header bytes give no result, except an empty frame ending on its last header byte; each
// payload byte gives one result with the unmasked byte, and the last one also carries tlast
// and the frame status. A fragmentation violation or an oversized control frame gives one
// error result, after which all input is swallowed without results until rst.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_data
  output logic       m_tlast,   // frame_end
  output logic [4:0] m_tuser    // [0] has_byte, [3:1] frame_status, [4] binary_message
);

  logic [2:0]  phase, phase_next;
  logic        final_flag, final_flag_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [63:0] len, len_next;
  logic [2:0]  hcnt, hcnt_next;
  logic [31:0] key, key_next;
  logic [1:0]  mpos, mpos_next;
  logic        in_frag, in_frag_next;
  logic        bin, bin_next;

  logic        s_fire;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;
  logic [7:0]  key_byte;
  logic [63:0] len_shift;
  logic        hdr_ok;

  assign s_fire = s_tvalid && s_tready;

  always_comb begin
    unique case (mpos)
      2'd0: key_byte = key[31:24];
      2'd1: key_byte = key[23:16];
      2'd2: key_byte = key[15:8];
      2'd3: key_byte = key[7:0];
    endcase
  end

  assign len_shift = {len[55:0], s_tdata};
  assign hdr_ok = in_frag ? (s_tdata[3:0] == OP_CONT)
                          : (s_tdata[7] || (s_tdata[3:0] != OP_CONT));

  always_comb begin
    phase_next      = phase;
    final_flag_next = final_flag;
    opcode_next     = opcode;
    masked_next     = masked;
    len_next        = len;
    hcnt_next       = hcnt;
    key_next        = key;
    mpos_next       = mpos;
    in_frag_next    = in_frag;
    bin_next        = bin;
    res_valid       = 1'b0;
    res             = '0;
    res.binary_message = bin;

    unique case (phase)
      PH_HDR0: begin
        if (!hdr_ok) begin
          phase_next       = PH_DEAD;
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = ST_ERROR;
        end else begin
          final_flag_next = s_tdata[7];
          opcode_next     = s_tdata[3:0];
          if (s_tdata[3:0] == OP_TEXT)   bin_next = 1'b0;
          if (s_tdata[3:0] == OP_BINARY) bin_next = 1'b1;
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        masked_next = s_tdata[7];
        if (opcode[3] && (s_tdata[6:0] > LEN_CTRL_MAX)) begin
          phase_next       = PH_DEAD;
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = ST_ERROR;
        end else begin
          key_next  = '0;
          mpos_next = '0;
          len_next  = '0;
          if (s_tdata[6:0] == LEN_EXT16 || s_tdata[6:0] == LEN_EXT64) begin
            hcnt_next  = (s_tdata[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
            phase_next = PH_EXTLEN;
          end else begin
            len_next = {57'd0, s_tdata[6:0]};
            if (s_tdata[7]) begin
              phase_next = PH_KEY;
              hcnt_next  = 3'd3;
            end else if (s_tdata[6:0] == 7'd0) begin
              in_frag_next     = !final_flag;
              phase_next       = PH_HDR0;
              res_valid        = 1'b1;
              res.frame_end    = 1'b1;
              res.frame_status = end_code(opcode, final_flag);
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXTLEN: begin
        len_next = len_shift;
        if (hcnt != 3'd0) begin
          hcnt_next = hcnt - 3'd1;
        end else if (masked) begin
          phase_next = PH_KEY;
          hcnt_next  = 3'd3;
        end else if (len_shift == 64'd0) begin
          in_frag_next     = !final_flag;
          phase_next       = PH_HDR0;
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = end_code(opcode, final_flag);
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_KEY: begin
        key_next = {key[23:0], s_tdata};
        if (hcnt != 3'd0) begin
          hcnt_next = hcnt - 3'd1;
        end else if (len == 64'd0) begin
          in_frag_next     = !final_flag;
          phase_next       = PH_HDR0;
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = end_code(opcode, final_flag);
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        mpos_next        = mpos + 2'd1;
        len_next         = len - 64'd1;
        res_valid        = 1'b1;
        res.has_byte     = 1'b1;
        res.payload_data = s_tdata ^ key_byte;
        if (len == 64'd1) begin
          in_frag_next     = !final_flag;
          phase_next       = PH_HDR0;
          res.frame_end    = 1'b1;
          res.frame_status = end_code(opcode, final_flag);
        end
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      final_flag <= 1'b0;
      opcode     <= OP_CONT;
      masked     <= 1'b0;
      len        <= '0;
      hcnt       <= '0;
      key        <= '0;
      mpos       <= '0;
      in_frag    <= 1'b0;
      bin        <= 1'b0;
    end else if (s_fire) begin
      phase      <= phase_next;
      final_flag <= final_flag_next;
      opcode     <= opcode_next;
      masked     <= masked_next;
      len        <= len_next;
      hcnt       <= hcnt_next;
      key        <= key_next;
      mpos       <= mpos_next;
      in_frag    <= in_frag_next;
      bin        <= bin_next;
    end
  end

  wsd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (s_fire && res_valid),
    .load_result (res),
    .load_ready  (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .result      (out_res)
  );

  assign m_tdata = out_res.payload_data;
  assign m_tlast = out_res.frame_end;
  assign m_tuser = {out_res.binary_message, out_res.frame_status, out_res.has_byte};

endmodule

// File: rtl/core/wsd_checker.sv
`include "assert_macros.svh"

module wsd_checker import wsd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [4:0] m_tuser
);

  `ASSERT_CLK(a_reset_empties, clk, rst |=> !m_tvalid, "output valid just after reset")

  `ASSERT_CLK_RST(a_stall_hold, clk, rst,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
    "stalled output transaction changed")

  `ASSERT_CLK_RST(a_mid_frame_status, clk, rst,
    m_tvalid && !m_tlast |-> m_tuser[0] && (m_tuser[3:1] == ST_FRAGMENT),
    "mid-frame result without byte or with status")

  `ASSERT_CLK_RST(a_error_no_byte, clk, rst,
    m_tvalid && (m_tuser[3:1] == ST_ERROR) |-> m_tlast && !m_tuser[0] && (m_tdata == 8'd0),
    "error result carries a payload byte")

  `ASSERT_CLK_RST(a_input_stall_cause, clk, rst,
    s_tvalid && !s_tready |-> m_tvalid && !m_tready,
    "input stalled while output register free")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: test/tb_websocket_frame_deframer.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int LEN_FORM_SHORT = 0;
  localparam int LEN_FORM_16    = 1;
  localparam int LEN_FORM_64    = 2;
  localparam int RANDOM_BYTES   = 400;
  localparam int STALL_LIMIT    = 5000;
  localparam int TAIL_CYCLES    = 20;

  localparam int END_CTRL_IN_FRAGMENT = 0;
  localparam int END_ORPHAN_CONT      = 1;
  localparam int END_DATA_IN_FRAGMENT = 2;
  localparam int END_LONG_CONTROL     = 3;
  localparam int END_HUGE_LENGTH      = 4;

  // Parses the byte stream alongside the block and holds the results still owed.
  class frame_scoreboard;
    logic [2:0]  phase;
    logic        fin_bit;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] bytes_left;
    logic [2:0]  hdr_count;
    logic [31:0] key;
    logic [1:0]  key_idx;
    logic        in_fragment;
    logic        is_binary;
    wsd_result_t owed_results[$];
    int          fails;

    function new();
      phase       = PH_HDR0;
      fin_bit     = 1'b0;
      opcode      = OP_CONT;
      masked      = 1'b0;
      bytes_left  = '0;
      hdr_count   = '0;
      key         = '0;
      key_idx     = '0;
      in_fragment = 1'b0;
      is_binary   = 1'b0;
      fails       = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void queue_result(logic hb, logic [7:0] data, logic fe, logic [2:0] st);
      wsd_result_t r;
      r.has_byte       = hb;
      r.payload_data   = data;
      r.frame_end      = fe;
      r.frame_status   = st;
      r.binary_message = is_binary;
      owed_results = {owed_results, r};
    endfunction

    function logic [2:0] end_of_frame();
      in_fragment = !fin_bit;
      phase       = PH_HDR0;
      case (opcode)
        OP_CLOSE: return ST_CLOSE;
        OP_PING:  return ST_PING;
        OP_PONG:  return ST_PONG;
        default:  return fin_bit ? ST_COMPLETE : ST_FRAGMENT;
      endcase
    endfunction

    function void raise_error();
      phase = PH_DEAD;
      queue_result(1'b0, 8'h00, 1'b1, ST_ERROR);
    endfunction

    function void length_known();
      if (masked) begin
        phase     = PH_KEY;
        hdr_count = 3'd3;
      end else if (bytes_left == 0) begin
        queue_result(1'b0, 8'h00, 1'b1, end_of_frame());
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [3:0] op;
      logic [6:0] len7;
      logic       legal;
      logic [7:0] plain;
      op   = b[3:0];
      len7 = b[6:0];
      case (phase)
        PH_HDR0: begin
          if (in_fragment) legal = (op == OP_CONT);
          else legal = b[7] || (op != OP_CONT);
          if (!legal) begin
            raise_error();
          end else begin
            fin_bit = b[7];
            opcode  = op;
            if (op == OP_TEXT) is_binary = 1'b0;
            if (op == OP_BINARY) is_binary = 1'b1;
            phase = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked = b[7];
          if (opcode >= OP_CLOSE && len7 > LEN_CTRL_MAX) begin
            raise_error();
          end else begin
            key        = '0;
            key_idx    = '0;
            bytes_left = '0;
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
              hdr_count = (len7 == LEN_EXT16) ? 3'd1 : 3'd7;
              phase     = PH_EXTLEN;
            end else begin
              bytes_left = 64'(len7);
              length_known();
            end
          end
        end
        PH_EXTLEN: begin
          bytes_left = {bytes_left[55:0], b};
          if (hdr_count != 0) hdr_count = hdr_count - 3'd1;
          else length_known();
        end
        PH_KEY: begin
          key = {key[23:0], b};
          if (hdr_count != 0) hdr_count = hdr_count - 3'd1;
          else if (bytes_left == 0) queue_result(1'b0, 8'h00, 1'b1, end_of_frame());
          else phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          plain      = b ^ key[31 - 8 * int'(key_idx) -: 8];
          key_idx    = key_idx + 2'd1;
          bytes_left = bytes_left - 64'd1;
          if (bytes_left == 0) queue_result(1'b1, plain, 1'b1, end_of_frame());
          else queue_result(1'b1, plain, 1'b0, ST_FRAGMENT);
        end
        default: ;
      endcase
    endfunction

    function void check_result(wsd_result_t got);
      wsd_result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        fails++;
        return;
      end
      want = owed_results.pop_front();
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte expected %0d actual %0d", want.has_byte, got.has_byte);
        fails++;
      end
      if (got.payload_data !== want.payload_data) begin
        $error("payload_data expected %0h actual %0h", want.payload_data, got.payload_data);
        fails++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end expected %0d actual %0d", want.frame_end, got.frame_end);
        fails++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status expected %0d actual %0d", want.frame_status, got.frame_status);
        fails++;
      end
      if (got.binary_message !== want.binary_message) begin
        $error("binary_message expected %0d actual %0d",
               want.binary_message, got.binary_message);
        fails++;
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [4:0] m_tuser;

  frame_scoreboard sb;
  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;
  logic in_message = 1'b0;
  int   random_sent = 0;
  int   idle_cycles = 0;

  websocket_frame_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Entered and left at a falling edge; s_tvalid is only lowered ahead of a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    random_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic mask_on,
                            input int len_form, input logic [63:0] len, input int body);
    logic [31:0] mask_word;
    logic [6:0]  len7;
    logic [2:0]  rsv;
    mask_word = $urandom;
    rsv       = 3'($urandom_range(0, 7));
    case (len_form)
      LEN_FORM_SHORT: len7 = len[6:0];
      LEN_FORM_16:    len7 = LEN_EXT16;
      default:        len7 = LEN_EXT64;
    endcase
    send_byte({fin, rsv, op});
    send_byte({mask_on, len7});
    if (len_form == LEN_FORM_16)
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (len_form == LEN_FORM_64)
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (mask_on)
      for (int i = 3; i >= 0; i--) send_byte(mask_word[8 * i +: 8]);
    repeat (body) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random_frame();
    logic [3:0] op;
    logic       fin;
    int         len_form;
    int         len;
    int         pick;
    send_burst = ($urandom_range(0, 3) == 0);
    pick       = $urandom_range(0, 15);
    len_form   = LEN_FORM_SHORT;
    if (in_message) begin
      op  = OP_CONT;
      fin = ($urandom_range(0, 2) == 0);
    end else if (pick < 10) begin
      op  = pick[0] ? OP_TEXT : OP_BINARY;
      fin = ($urandom_range(0, 2) != 0);
    end else if (pick < 14) begin
      op  = OP_CLOSE + 4'($urandom_range(0, 7));
      fin = ($urandom_range(0, 5) != 0);
    end else begin
      op  = 4'($urandom_range(3, 7));
      fin = 1'($urandom_range(0, 1));
    end
    if (op >= OP_CLOSE) begin
      len = ($urandom_range(0, 19) == 0) ? int'(LEN_CTRL_MAX) : $urandom_range(0, 6);
    end else begin
      len = ($urandom_range(0, 39) == 0) ? int'(LEN_CTRL_MAX) : $urandom_range(0, 10);
      case ($urandom_range(0, 7))
        0: len_form = LEN_FORM_16;
        1: len_form = LEN_FORM_64;
        default: ;
      endcase
      if (len_form != LEN_FORM_SHORT) len = $urandom_range(0, 10);
    end
    send_frame(fin, op, 1'($urandom_range(0, 1)), len_form, 64'(len), len);
    in_message = !fin;
  endtask

  task automatic send_ending();
    logic [63:0] huge;
    logic        ctrl_long;
    if (in_message) send_frame(1'b1, OP_CONT, 1'b1, LEN_FORM_SHORT, 64'd2, 2);
    in_message = 1'b0;
    case ($urandom_range(END_CTRL_IN_FRAGMENT, END_HUGE_LENGTH))
      END_CTRL_IN_FRAGMENT: begin
        send_frame(1'b0, OP_TEXT, 1'b0, LEN_FORM_SHORT, 64'd1, 1);
        send_frame(1'b1, OP_PING, 1'b0, LEN_FORM_SHORT, 64'd0, 0);
      end
      END_ORPHAN_CONT: send_frame(1'b0, OP_CONT, 1'b0, LEN_FORM_SHORT, 64'd1, 1);
      END_DATA_IN_FRAGMENT: begin
        send_frame(1'b0, OP_BINARY, 1'b1, LEN_FORM_SHORT, 64'd1, 1);
        send_frame(1'b1, OP_TEXT, 1'b0, LEN_FORM_SHORT, 64'd1, 1);
      end
      END_LONG_CONTROL: begin
        ctrl_long = 1'($urandom_range(0, 1));
        send_frame(1'b1, OP_CLOSE + 4'($urandom_range(0, 7)), 1'b0,
                   ctrl_long ? LEN_FORM_64 : LEN_FORM_16, 64'd0, 0);
      end
      default: begin
        huge = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(1'b1, OP_BINARY, 1'b1, LEN_FORM_64, huge, 40);
      end
    endcase
    // bytes after an error are swallowed; after a huge frame they are payload
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_frame(1'b1, OP_TEXT,   1'b0, LEN_FORM_SHORT, 64'd0, 0);
    send_frame(1'b1, OP_BINARY, 1'b1, LEN_FORM_SHORT, 64'd1, 1);
    send_frame(1'b1, OP_PING,   1'b0, LEN_FORM_SHORT, 64'd1, 1);
    send_frame(1'b1, OP_CLOSE,  1'b0, LEN_FORM_SHORT, 64'd0, 0);
    send_frame(1'b1, OP_PONG,   1'b0, LEN_FORM_SHORT, 64'd0, 0);
    send_frame(1'b0, OP_TEXT,   1'b0, LEN_FORM_SHORT, 64'd1, 1);
    send_frame(1'b0, OP_CONT,   1'b0, LEN_FORM_SHORT, 64'd0, 0);
    send_frame(1'b1, OP_CONT,   1'b0, LEN_FORM_SHORT, 64'd1, 1);
    send_frame(1'b1, OP_TEXT,   1'b0, LEN_FORM_16,    64'd0, 0);
    hold_until_drained();

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 24) == 0) hold_until_drained();
      send_random_frame();
    end
    send_ending();
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    wsd_result_t seen;
    seen = {m_tuser[0], m_tdata, m_tlast, m_tuser[3:1], m_tuser[4]};
    if (!rst && m_tvalid && m_tready) sb.check_result(seen);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
